// ----- rtl/core/csvmsa_pkg.sv -----
// package: types and constants for the monthly sum aggregator
`default_nettype none
package csvmsa_pkg;

  localparam int TableDepth = 64;
  localparam int IdxW       = 6;
  localparam int FillW      = 7;

  localparam logic [7:0] SepChar   = 8'h3B;
  localparam logic [7:0] NlChar    = 8'h0A;
  localparam logic [7:0] MinusChar = 8'h2D;
  localparam logic [7:0] ZeroChar  = 8'h30;
  localparam logic [7:0] NineChar  = 8'h39;
  localparam logic [30:0] Max31    = 31'h7FFF_FFFF;
  localparam logic [19:0] Million  = 20'd1000000;
  localparam logic [19:0] HalfMillion = 20'd500000;

  // ceil(2^59 / 15625) split into two 23-bit halves, exact for 45-bit dividends
  localparam logic [22:0] RecipLo = 23'd4287452;
  localparam logic [22:0] RecipHi = 23'd4398046;

  // command codes
  localparam logic [1:0] CmdByte  = 2'd0;
  localparam logic [1:0] CmdFlush = 2'd1;
  localparam logic [1:0] CmdRead  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] RegDateCol = 2'd0;
  localparam logic [1:0] RegAmtCol  = 2'd1;
  localparam logic [1:0] RegPpm     = 2'd2;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] text_byte;
    logic [5:0] entry_index;
  } req_t;

  typedef struct packed {
    logic        entry_valid;
    logic [13:0] entry_year;
    logic [6:0]  entry_month;
    logic [30:0] month_sum;
    logic [30:0] share_cents;
    logic [6:0]  entry_count;
  } res_t;

  // finished line handed from the parser to the table
  typedef struct packed {
    logic        valid;
    logic [13:0] year;
    logic [6:0]  month;
    logic [30:0] amount;
  } line_t;

  // digit value of a character, non-digits count as zero
  function automatic logic [3:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = c - ZeroChar;
    digit_of = (c >= ZeroChar && c <= NineChar) ? d[3:0] : 4'd0;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/csv_monthly_sum_aggregator_unit.sv -----
// top level of the monthly sum aggregator
// channel  | ports                         | direction
// request  | start_i, busy_o, req_i        | in
// result   | res_valid_o, res_o            | out
// config   | cfg_we_i, cfg_idx_i, cfg_data_i| in
// a text byte, flush or unused command: the next request is taken once hold_q clears.
// a line end that reaches the table: a sequential search of the entries in the
// single table memory, then an append or a write-back.
// a read: table read, multiply, four multiply-accumulate steps, then the result
// strobe; the next request is taken as it ends.
// busy_o is high while any of this runs; the receiver cannot stall results.
// reset clears all line state and the entry count; table contents need no clear.
`default_nettype none
module csv_monthly_sum_aggregator_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire csvmsa_pkg::req_t   req_i,
  output logic                    res_valid_o,
  output csvmsa_pkg::res_t        res_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [19:0]        cfg_data_i
);

  logic [5:0]  date_col_q, amt_col_q;
  logic [19:0] ppm_q;
  logic        acc, hold_q;
  csvmsa_pkg::line_t line;
  logic        tbl_busy, rd_done, rd_valid, sh_busy, sh_done, pend_q, rv_q;
  logic [51:0] rd_data, ent_q;
  logic [6:0]  fill;
  logic [30:0] share;

  assign acc = start_i && !busy_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      date_col_q <= 6'd0; amt_col_q <= 6'd10; ppm_q <= 20'd3000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        csvmsa_pkg::RegDateCol: date_col_q <= cfg_data_i[5:0];
        csvmsa_pkg::RegAmtCol:  amt_col_q  <= cfg_data_i[5:0];
        csvmsa_pkg::RegPpm:     ppm_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  csvmsa_parser u_parser (
    .clk_i, .rst_ni,
    .byte_i (acc && req_i.command == csvmsa_pkg::CmdByte),
    .flush_i(acc && req_i.command == csvmsa_pkg::CmdFlush),
    .char_i (req_i.text_byte),
    .date_col_i(date_col_q), .amt_col_i(amt_col_q),
    .ppm_zero_i(ppm_q == '0),
    .line_o (line)
  );

  csvmsa_table u_table (
    .clk_i, .rst_ni, .line_i(line),
    .rd_i(acc && req_i.command == csvmsa_pkg::CmdRead),
    .rd_idx_i(req_i.entry_index),
    .busy_o(tbl_busy), .rd_done_o(rd_done), .rd_data_o(rd_data),
    .rd_valid_o(rd_valid), .fill_o(fill)
  );

  csvmsa_share u_share (
    .clk_i, .rst_ni, .start_i(rd_done), .sum_i(rd_data[30:0]), .ppm_i(ppm_q),
    .busy_o(sh_busy), .done_o(sh_done), .share_o(share)
  );

  // gap after each request, held by hold_q, so the parser output reaches the table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0; pend_q <= 1'b0; rv_q <= 1'b0; res_valid_o <= 1'b0;
    end else begin
      hold_q <= acc;
      if (rd_done) begin
        pend_q <= 1'b1; rv_q <= rd_valid;
      end else if (sh_done) pend_q <= 1'b0;
      res_valid_o <= sh_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_done) ent_q <= rd_data;
    if (sh_done) begin
      res_o.entry_valid <= rv_q;
      res_o.entry_year  <= rv_q ? ent_q[51:38] : '0;
      res_o.entry_month <= rv_q ? ent_q[37:31] : '0;
      res_o.month_sum   <= rv_q ? ent_q[30:0] : '0;
      res_o.share_cents <= rv_q ? share : '0;
      res_o.entry_count <= fill;
    end
  end

  assign busy_o = hold_q || tbl_busy || sh_busy || pend_q || rd_done;

endmodule
`default_nettype wire

// ----- rtl/core/csvmsa_parser.sv -----
// line parser: column counting, date capture and amount accumulation
`default_nettype none
module csvmsa_parser (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 byte_i,
  input  wire logic                 flush_i,
  input  wire logic [7:0]           char_i,
  input  wire logic [5:0]           date_col_i,
  input  wire logic [5:0]           amt_col_i,
  input  wire logic                 ppm_zero_i,
  output csvmsa_pkg::line_t         line_o
);

  logic [5:0]  col_q, col_d;
  logic [3:0]  pos_q, pos_d;
  logic [3:0]  dig_q [6];
  logic [3:0]  dig_d [6];
  logic [30:0] acc_q, acc_d;
  logic        seen_q, seen_d, neg_q, neg_d, pend_q, pend_d;
  logic        end_line;
  logic [34:0] acc_x10;
  logic [3:0]  cdig;
  logic [6:0]  month;
  logic [13:0] year;

  assign cdig    = csvmsa_pkg::digit_of(char_i);
  assign acc_x10 = {acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {31'd0, cdig};
  assign end_line = (byte_i && char_i == csvmsa_pkg::NlChar) || (flush_i && pend_q);

  // key from captured digits
  assign month = 7'(dig_q[0]) * 7'd10 + 7'(dig_q[1]);
  assign year  = 14'(dig_q[2]) * 14'd1000 + 14'(dig_q[3]) * 14'd100
               + 14'(dig_q[4]) * 14'd10 + 14'(dig_q[5]);

  // next line state
  always_comb begin
    col_d = col_q; pos_d = pos_q; acc_d = acc_q;
    seen_d = seen_q; neg_d = neg_q; pend_d = pend_q;
    for (int i = 0; i < 6; i++) dig_d[i] = dig_q[i];
    if (end_line) begin
      col_d = '0; pos_d = '0; acc_d = '0; seen_d = 1'b0; neg_d = 1'b0; pend_d = 1'b0;
      for (int i = 0; i < 6; i++) dig_d[i] = '0;
    end else if (byte_i) begin
      pend_d = 1'b1;
      if (char_i == csvmsa_pkg::SepChar) begin
        if (col_q != 6'd63) col_d = col_q + 6'd1;
      end else if (col_q == amt_col_i) begin
        if (!seen_q && char_i == csvmsa_pkg::MinusChar) neg_d = 1'b1;
        seen_d = 1'b1;
        if (char_i >= csvmsa_pkg::ZeroChar && char_i <= csvmsa_pkg::NineChar) begin
          acc_d = (acc_x10 > 35'(csvmsa_pkg::Max31)) ? csvmsa_pkg::Max31 : acc_x10[30:0];
        end
      end else if (col_q == date_col_i) begin
        if (pos_q == 4'd3 || pos_q == 4'd4) dig_d[3'(pos_q - 4'd3)] = cdig;
        else if (pos_q >= 4'd6 && pos_q <= 4'd9) dig_d[3'(pos_q - 4'd4)] = cdig;
        if (pos_q != 4'd15) pos_d = pos_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0; pos_q <= '0; acc_q <= '0;
      seen_q <= 1'b0; neg_q <= 1'b0; pend_q <= 1'b0;
      for (int i = 0; i < 6; i++) dig_q[i] <= '0;
      line_o <= '0;
    end else begin
      col_q <= col_d; pos_q <= pos_d; acc_q <= acc_d;
      seen_q <= seen_d; neg_q <= neg_d; pend_q <= pend_d;
      for (int i = 0; i < 6; i++) dig_q[i] <= dig_d[i];
      line_o.valid  <= end_line && !ppm_zero_i && !neg_q && (acc_q != '0);
      line_o.year   <= year;
      line_o.month  <= month;
      line_o.amount <= acc_q;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/csvmsa_table.sv -----
// key table: sequential search and read-modify-write in one memory
`default_nettype none
module csvmsa_table (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire csvmsa_pkg::line_t   line_i,
  input  wire logic                rd_i,
  input  wire logic [5:0]          rd_idx_i,
  output logic                     busy_o,
  output logic                     rd_done_o,
  output logic [51:0]              rd_data_o,
  output logic                     rd_valid_o,
  output logic [6:0]               fill_o
);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StScan  = 5'b00010,
    StCheck = 5'b00100,
    StRead  = 5'b01000,
    StWrite = 5'b10000
  } state_e;

  // entry word: year, month, sum
  logic [51:0] mem [csvmsa_pkg::TableDepth];
  logic [51:0] rdata_q;
  logic        we;
  logic [5:0]  waddr, raddr;
  logic [51:0] wdata;

  state_e      st_q, st_d;
  logic [6:0]  fill_q, fill_d;
  logic [6:0]  ptr_q, ptr_d;
  logic [13:0] year_q, year_d;
  logic [6:0]  month_q, month_d;
  logic [30:0] amt_q, amt_d;
  logic        rv_q, rv_d;
  logic [31:0] sum_add;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  assign sum_add = {1'b0, rdata_q[30:0]} + {1'b0, amt_q};

  // search sequencer
  always_comb begin
    st_d = st_q; fill_d = fill_q; ptr_d = ptr_q; year_d = year_q;
    month_d = month_q; amt_d = amt_q; rv_d = rv_q;
    we = 1'b0; waddr = ptr_q[5:0]; wdata = '0; raddr = ptr_q[5:0];
    rd_done_o = 1'b0;
    case (st_q)
      StIdle: begin
        if (line_i.valid) begin
          year_d = line_i.year; month_d = line_i.month; amt_d = line_i.amount;
          ptr_d = '0; raddr = '0; st_d = StScan;
        end else if (rd_i) begin
          raddr = rd_idx_i; rv_d = {1'b0, rd_idx_i} < fill_q; st_d = StRead;
        end
      end
      StScan: begin
        // read issued for ptr, data arrives next cycle
        if (ptr_q >= fill_q) begin
          if (fill_q != 7'(csvmsa_pkg::TableDepth)) begin
            we = 1'b1; waddr = fill_q[5:0]; wdata = {year_q, month_q, amt_q};
            fill_d = fill_q + 7'd1;
          end
          st_d = StIdle;
        end else st_d = StCheck;
      end
      StCheck: begin
        if (rdata_q[51:38] == year_q && rdata_q[37:31] == month_q) begin
          st_d = StWrite;
        end else begin
          ptr_d = ptr_q + 7'd1; raddr = 6'(ptr_q + 7'd1); st_d = StScan;
        end
      end
      StWrite: begin
        we = 1'b1;
        wdata = {year_q, month_q, sum_add[31] ? csvmsa_pkg::Max31 : sum_add[30:0]};
        st_d = StIdle;
      end
      StRead: begin
        rd_done_o = 1'b1; st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; fill_q <= '0; ptr_q <= '0; rv_q <= 1'b0;
    end else begin
      st_q <= st_d; fill_q <= fill_d; ptr_q <= ptr_d; rv_q <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    year_q <= year_d; month_q <= month_d; amt_q <= amt_d;
  end

  assign busy_o     = (st_q != StIdle) || line_i.valid;
  assign rd_data_o  = rdata_q;
  assign rd_valid_o = rv_q;
  assign fill_o     = fill_q;

endmodule
`default_nettype wire

// ----- rtl/core/csvmsa_share.sv -----
// share unit: sum times ppm, then rounded division by one million
`default_nettype none
module csvmsa_share (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [30:0] sum_i,
  input  wire logic [19:0] ppm_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [30:0]      share_o
);

  // one million is 64 * 15625: drop six bits, then multiply by the scaled
  // reciprocal of 15625 as four 23 x 23 bit partial products, one a cycle
  logic [44:0] num_q;
  logic [90:0] acc_q;
  logic [1:0]  step_q;
  logic        run_q, mul_q;
  logic [30:0] sum_q;
  logic [19:0] ppm_q;
  logic [50:0] prod;
  logic [22:0] op_a, op_b;
  logic [45:0] part;
  logic [90:0] part_sh;
  logic [31:0] quot;

  assign prod = 51'(sum_q) * 51'(ppm_q) + 51'(csvmsa_pkg::HalfMillion);

  // partial product operands and their weight
  always_comb begin
    case (step_q)
      2'd0: begin
        op_a = num_q[22:0]; op_b = csvmsa_pkg::RecipLo;
      end
      2'd1: begin
        op_a = {1'b0, num_q[44:23]}; op_b = csvmsa_pkg::RecipLo;
      end
      2'd2: begin
        op_a = num_q[22:0]; op_b = csvmsa_pkg::RecipHi;
      end
      default: begin
        op_a = {1'b0, num_q[44:23]}; op_b = csvmsa_pkg::RecipHi;
      end
    endcase
  end

  assign part = op_a * op_b;

  always_comb begin
    case (step_q)
      2'd0:       part_sh = 91'(part);
      2'd1, 2'd2: part_sh = 91'(part) << 23;
      default:    part_sh = 91'(part) << 46;
    endcase
  end

  // sequencing: capture, multiply, four accumulate steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0; mul_q <= 1'b0; done_o <= 1'b0; step_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        mul_q <= 1'b1;
      end else if (mul_q) begin
        mul_q <= 1'b0; run_q <= 1'b1; step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          run_q <= 1'b0; done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sum_q <= sum_i; ppm_q <= ppm_i;
    end else if (mul_q) begin
      num_q <= prod[50:6]; acc_q <= '0;
    end else if (run_q) begin
      acc_q <= acc_q + part_sh;
    end
  end

  // quotient is the top of the accumulator, saturated to 31 bits
  assign quot    = acc_q[90:59];
  assign share_o = quot[31] ? csvmsa_pkg::Max31 : quot[30:0];
  assign busy_o  = start_i || mul_q || run_q;

endmodule
`default_nettype wire

// ----- dv/tb_csv_monthly_sum_aggregator_unit.sv -----
// testbench: csv monthly sum aggregator, scoreboard class with a line and table predictor
`timescale 1ns / 1ps
module tb_csv_monthly_sum_aggregator_unit;
  import csvmsa_pkg::*;

  localparam int unsigned MaxSum = 32'h7FFF_FFFF;
  localparam longint CycleLimit = 2_000_000;
  localparam logic [1:0] CmdUnused = 2'd3;

  // predictor of the parser and table, with its own expected entry reads
  class month_table_sb;
    bit [5:0]  date_col, amt_col;
    bit [19:0] ppm;
    bit [5:0]  col;
    bit [3:0]  dpos;
    bit [3:0]  digs[6];
    bit [30:0] amt;
    bit        amt_seen, amt_neg, pending;
    bit [13:0] t_year[TableDepth];
    bit [6:0]  t_month[TableDepth];
    bit [30:0] t_sum[TableDepth];
    int        fill;
    res_t      pending_reads[$];
    int        errors;
    int        shown;

    function new();
      date_col = 0; amt_col = 10; ppm = 3000;
      fill = 0; errors = 0; shown = 0;
      clear_line();
    endfunction

    function void clear_line();
      col = 0; dpos = 0; amt = 0; amt_seen = 0; amt_neg = 0; pending = 0;
      foreach (digs[i]) digs[i] = 0;
    endfunction

    function void set_reg(bit [1:0] idx, bit [19:0] val);
      case (idx)
        RegDateCol: date_col = val[5:0];
        RegAmtCol:  amt_col = val[5:0];
        RegPpm:     ppm = val;
        default: ;
      endcase
    endfunction

    function bit [3:0] dval(bit [7:0] c);
      return (c >= ZeroChar && c <= NineChar) ? 4'(c - ZeroChar) : 4'd0;
    endfunction

    // close a line: with a nonzero ppm, a positive amount goes to its year and month entry
    function void close_line();
      int unsigned yr, mo;
      longint unsigned s;
      bit hit;
      hit = 0;
      if (ppm != 0 && !amt_neg && amt > 0) begin
        mo = digs[0] * 10 + digs[1];
        yr = digs[2] * 1000 + digs[3] * 100 + digs[4] * 10 + digs[5];
        for (int i = 0; i < fill; i++) begin
          if (!hit && t_year[i] == yr && t_month[i] == mo) begin
            s = longint'(t_sum[i]) + amt;
            t_sum[i] = (s > MaxSum) ? 31'(MaxSum) : 31'(s);
            hit = 1;
          end
        end
        if (!hit && fill < TableDepth) begin
          t_year[fill] = 14'(yr); t_month[fill] = 7'(mo); t_sum[fill] = amt;
          fill++;
        end
      end
      clear_line();
    endfunction

    // note one accepted request
    function void note_request(req_t r);
      longint unsigned a, sh;
      res_t e;
      case (r.command)
        CmdByte: begin
          if (r.text_byte == SepChar) begin
            pending = 1;
            if (col < 63) col++;
          end else if (r.text_byte == NlChar) begin
            close_line();
          end else begin
            pending = 1;
            if (col == amt_col) begin
              if (!amt_seen && r.text_byte == MinusChar) amt_neg = 1;
              amt_seen = 1;
              if (r.text_byte >= ZeroChar && r.text_byte <= NineChar) begin
                a = longint'(amt) * 10 + (r.text_byte - ZeroChar);
                amt = (a > MaxSum) ? 31'(MaxSum) : 31'(a);
              end
            end else if (col == date_col) begin
              if (dpos == 3 || dpos == 4) digs[dpos - 3] = dval(r.text_byte);
              else if (dpos >= 6 && dpos <= 9) digs[dpos - 4] = dval(r.text_byte);
              if (dpos < 15) dpos++;
            end
          end
        end
        CmdFlush: if (pending) close_line();
        CmdRead: begin
          e = '0;
          if (r.entry_index < fill) begin
            e.entry_valid = 1;
            e.entry_year = t_year[r.entry_index];
            e.entry_month = t_month[r.entry_index];
            e.month_sum = t_sum[r.entry_index];
            sh = (longint'(e.month_sum) * ppm + 500000) / 1000000;
            e.share_cents = (sh > MaxSum) ? 31'(MaxSum) : 31'(sh);
          end
          e.entry_count = 7'(fill);
          pending_reads.push_back(e);
        end
        default: ;
      endcase
    endfunction

    // compare one result with the oldest expected read
    function void check_result(res_t got);
      res_t e;
      if (pending_reads.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result %h", got);
        end
        return;
      end
      e = pending_reads.pop_front();
      if (got !== e) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("mismatch: exp v%0d y%0d m%0d s%0d sh%0d n%0d",
                   e.entry_valid, e.entry_year, e.entry_month, e.month_sum,
                   e.share_cents, e.entry_count);
          $display("          got v%0d y%0d m%0d s%0d sh%0d n%0d",
                   got.entry_valid, got.entry_year, got.entry_month,
                   got.month_sum, got.share_cents, got.entry_count);
        end
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy, res_valid, cfg_we;
  req_t req;
  res_t res;
  logic [1:0]  cfg_idx;
  logic [19:0] cfg_data;
  month_table_sb sb;
  longint cycles = 0;

  csv_monthly_sum_aggregator_unit dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy), .req_i(req),
    .res_valid_o(res_valid), .res_o(res), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // result sampling and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && res_valid) sb.check_result(res);
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // drive one request, wait for acceptance
  task automatic send(bit [1:0] cmd, bit [7:0] b, bit [5:0] idx);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    repeat (gap) @(negedge clk);
    req.command = cmd; req.text_byte = b; req.entry_index = idx;
    start = 1;
    do @(posedge clk); while (busy);
    sb.note_request(req);
    @(negedge clk);
    start = 0;
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) send(CmdByte, s[i], 0);
  endtask

  // wait until idle, then write a register
  task automatic write_reg(bit [1:0] idx, bit [19:0] val);
    while (sb.pending_reads.size() != 0) @(negedge clk);
    repeat (TableDepth * 2 + 80) @(negedge clk);
    cfg_we = 1; cfg_idx = idx; cfg_data = val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 0;
  endtask

  // one well-formed line with random content
  task automatic rand_line(int ncol);
    string s;
    int dc, ac;
    dc = sb.date_col; ac = sb.amt_col;
    s = "";
    for (int c = 0; c < ncol; c++) begin
      if (c != 0) s = {s, ";"};
      if (c == ac) begin
        if ($urandom_range(0, 7) == 0) s = {s, "-"};
        if ($urandom_range(0, 15) == 0) s = {s, "99999999999"};
        else s = {s, $sformatf("%0d", $urandom_range(0, 99999))};
      end else if (c == dc) begin
        s = {s, $sformatf("%02d.%02d.%04d", $urandom_range(1, 28),
                          $urandom_range(1, 3), $urandom_range(2020, 2021))};
      end else if ($urandom_range(0, 1)) begin
        s = {s, "x"};
      end
    end
    put_text(s);
    if ($urandom_range(0, 5) == 0) send(CmdFlush, 0, 0);
    else send(CmdByte, NlChar, 0);
  endtask

  initial begin
    sb = new();
    start = 0; req = '0; cfg_we = 0; cfg_idx = 0; cfg_data = 0;
    rst_n = 0;
    repeat (3) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed: reset columns, amount in column 10
    send(CmdRead, 0, 0);
    send(CmdFlush, 0, 0);
    put_text("15.03.2021;a;b;c;d;e;f;g;h;i;12345\n");
    put_text("1x.0a.20z1;;;;;;;;;;-77\n");
    put_text("01.03.2021;;;;;;;;;;0\n");
    send(CmdByte, 8'h00, 0);
    send(CmdByte, 8'hFF, 0);
    send(CmdFlush, 0, 0);
    send(CmdUnused, 8'hAA, 6'h3F);
    send(CmdRead, 0, 0);
    send(CmdRead, 0, 6'h3F);

    // same column for date and amount, big ppm and saturation, then high columns with ppm zero
    write_reg(RegDateCol, 0);
    write_reg(RegAmtCol, 0);
    write_reg(RegPpm, 1000000);
    put_text("99999999999\n");
    put_text("2147483647\n");
    send(CmdRead, 0, 1);
    write_reg(RegAmtCol, 63);
    write_reg(RegDateCol, 62);
    write_reg(RegPpm, 0);
    put_text("12.34.5678.99999;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;;");
    put_text(";;;;;;;;5\n");
    send(CmdRead, 0, 1);

    // random phases with varying register settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(RegDateCol, $urandom_range(0, 3));
      write_reg(RegAmtCol, (ph == 5) ? 63 : $urandom_range(0, 4));
      write_reg(RegPpm, (ph == 0) ? 20'd1000000 : (ph == 1) ? 20'd0 :
                        20'($urandom_range(1, 1000000)));
      for (int k = 0; k < ((ph == 5) ? 2 : 8); k++) begin
        case ((ph == 5) ? 9 : $urandom_range(0, 9))
          0: send(CmdByte, 8'($urandom), 0);
          1: send(2'($urandom), 8'($urandom), 6'($urandom));
          2, 3: send(CmdRead, 0, 6'($urandom_range(0, 5)));
          default: rand_line((ph == 5) ? 64 : 6);
        endcase
      end
    end

    // fill the table with new keys, then hit existing ones while full
    write_reg(RegDateCol, 0);
    write_reg(RegAmtCol, 1);
    write_reg(RegPpm, 20'($urandom_range(1, 1000000)));
    for (int k = 0; k < 72; k++) begin
      put_text($sformatf("01.%02d;1\n", k % 70));
      if (k % 3 == 0) send(CmdRead, 0, 6'($urandom));
    end
    send(CmdRead, 0, 6'd63);

    while (sb.pending_reads.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
